@@ hdl/cfrc_pkg.sv @@
// Shared types, constants and the CRC-16/Modbus byte update for the command frame receiver.
// Used by every module in hdl/; depends on nothing.
package cfrc_pkg;

  // Reset values of the command code registers
  localparam logic [7:0] WRITE_CMD_RESET = 8'd87;
  localparam logic [7:0] READ_CMD_RESET  = 8'd82;

  // Configuration register indexes
  localparam logic [1:0] REG_WRITE_CMD = 2'd0;
  localparam logic [1:0] REG_READ_CMD  = 2'd1;

  // CRC-16/Modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD_CRC = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Work the back end does for one request
  typedef enum logic [2:0] {
    OP_START  = 3'd0,  // command byte: restart CRC and fold it in
    OP_HDR    = 3'd1,  // function or length byte: fold into CRC
    OP_DATA   = 3'd2,  // payload byte: fold into CRC and pass out
    OP_CRC_LO = 3'd3,  // hold received CRC low byte
    OP_CRC_HI = 3'd4   // compare and report frame status
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx;
    logic       is_read;
    logic [7:0] func;
    logic [7:0] len;
  } q_entry_t;

  // Fold one byte into the running CRC, reflected, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/command_frame_receiver_crc16.sv @@
// Top level of the framed command receiver with CRC-16/Modbus check.
// Instantiates cfrc_front, cfrc_queue and cfrc_back; depends on cfrc_pkg.
//
//   channel   | signals                              | carries
//   ----------+--------------------------------------+-----------------------------------
//   s_axis    | s_tvalid s_tready s_tdata[7:0]       | received byte
//   m_axis    | m_tvalid m_tready m_tdata m_tuser    | payload byte or frame status
//             | m_tlast                              | (tlast marks frame status)
//   cfg       | cfg_we cfg_index cfg_wdata           | command code register writes
//
// One byte per cycle sustained while the queue is not full; the back end folds a byte into the CRC as it pops it.
// A request is registered in the queue, then its result is registered in the back end's output register.
// A stalled output fills the two-entry queue; s_tready drops only when the queue is full.
// Synchronous reset restores command codes 87 (write) and 82 (read) and starts hunting.
module command_frame_receiver_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] is_read, [8:1] func_code, [16:9] payload_len,
                                 // [24:17] data_byte, [31:25] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  cfrc_pkg::q_entry_t push_data;
  cfrc_pkg::q_entry_t head;
  logic               push;
  logic               pop;
  logic               full;
  logic               not_empty;
  logic               is_read;
  logic [7:0]         func;
  logic [7:0]         len;
  logic [7:0]         data;

  cfrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .q_full    (full),
    .in_ready  (s_tready),
    .q_push    (push),
    .q_data    (push_data)
  );

  cfrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  cfrc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_kind    (m_tuser),
    .out_is_read (is_read),
    .out_func    (func),
    .out_len     (len),
    .out_data    (data),
    .out_last    (m_tlast)
  );

  // Pack result fields, lowest first
  assign m_tdata = {7'd0, data, len, func, is_read};

endmodule

@@ hdl/cfrc_front.sv @@
// Front end: takes received bytes, tracks the frame layout and tags each frame byte.
// Holds the command code registers. Depends on cfrc_pkg.
module cfrc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               q_full,
  output logic               in_ready,
  output logic               q_push,
  output cfrc_pkg::q_entry_t q_data
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FUNC,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRCLO,
    PH_CRCHI
  } phase_t;

  phase_t     phase;
  logic [7:0] write_cmd;
  logic [7:0] read_cmd;
  logic       frame_is_read;
  logic [7:0] held_func;
  logic [7:0] held_len;
  logic [7:0] bytes_left;
  logic       accept;
  logic       is_cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cmd   = (in_byte == write_cmd) || (in_byte == read_cmd);

  // Tag the incoming byte for the back end
  always_comb begin
    q_data.rx      = in_byte;
    q_data.is_read = frame_is_read;
    q_data.func    = held_func;
    q_data.len     = frame_is_read ? 8'd0 : held_len;
    q_data.op      = cfrc_pkg::OP_HDR;
    q_push         = 1'b0;
    case (phase)
      PH_HUNT: begin
        q_data.op = cfrc_pkg::OP_START;
        q_push    = accept && is_cmd;
      end
      PH_FUNC, PH_LEN: begin
        q_data.op = cfrc_pkg::OP_HDR;
        q_push    = accept;
      end
      PH_PAYLOAD: begin
        q_data.op = cfrc_pkg::OP_DATA;
        q_push    = accept;
      end
      PH_CRCLO: begin
        q_data.op = cfrc_pkg::OP_CRC_LO;
        q_push    = accept;
      end
      PH_CRCHI: begin
        q_data.op = cfrc_pkg::OP_CRC_HI;
        q_push    = accept;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // Advance the frame parser and take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      write_cmd     <= cfrc_pkg::WRITE_CMD_RESET;
      read_cmd      <= cfrc_pkg::READ_CMD_RESET;
      frame_is_read <= 1'b0;
      held_func     <= 8'd0;
      held_len      <= 8'd0;
      bytes_left    <= 8'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == cfrc_pkg::REG_WRITE_CMD) begin
          write_cmd <= cfg_wdata;
        end else if (cfg_index == cfrc_pkg::REG_READ_CMD) begin
          read_cmd <= cfg_wdata;
        end
      end
      if (accept) begin
        case (phase)
          PH_HUNT: begin
            if (is_cmd) begin
              frame_is_read <= (in_byte != write_cmd);
              held_func     <= 8'd0;
              held_len      <= 8'd0;
              bytes_left    <= 8'd0;
              phase         <= PH_FUNC;
            end
          end
          PH_FUNC: begin
            held_func <= in_byte;
            phase     <= frame_is_read ? PH_CRCLO : PH_LEN;
          end
          PH_LEN: begin
            held_len   <= in_byte;
            bytes_left <= in_byte;
            phase      <= (in_byte == 8'd0) ? PH_CRCLO : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            bytes_left <= bytes_left - 8'd1;
            if (bytes_left == 8'd1) begin
              phase <= PH_CRCLO;
            end
          end
          PH_CRCLO: begin
            phase <= PH_CRCHI;
          end
          PH_CRCHI: begin
            phase <= PH_HUNT;
          end
          default: begin
            phase <= PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

@@ hdl/cfrc_queue.sv @@
// Short request queue between the front and back ends.
// Register-based FIFO of cfrc_pkg::q_entry_t, depth from cfrc_pkg.
module cfrc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cfrc_pkg::q_entry_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output cfrc_pkg::q_entry_t head
);

  cfrc_pkg::q_entry_t                 slots [cfrc_pkg::QUEUE_DEPTH];
  logic [cfrc_pkg::QUEUE_AW-1:0]      wr_ptr;
  logic [cfrc_pkg::QUEUE_AW-1:0]      rd_ptr;
  logic [cfrc_pkg::QUEUE_AW:0]        count;

  assign full      = (count == (cfrc_pkg::QUEUE_AW+1)'(cfrc_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == (cfrc_pkg::QUEUE_AW)'(cfrc_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == (cfrc_pkg::QUEUE_AW)'(cfrc_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/cfrc_back.sv @@
// Back end: runs the CRC over tagged bytes and drives the result register.
// Depends on cfrc_pkg.
module cfrc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  cfrc_pkg::q_entry_t q_head,
  output logic               q_pop,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic               out_is_read,
  output logic [7:0]         out_func,
  output logic [7:0]         out_len,
  output logic [7:0]         out_data,
  output logic               out_last
);

  logic [15:0] running_crc;
  logic [7:0]  got_crc_low;
  logic [15:0] crc_seed;
  logic [15:0] crc_next;
  logic        needs_out;
  logic        emit;
  logic        good;

  // Pop when the request makes no result or the output slot frees up
  assign needs_out = (q_head.op == cfrc_pkg::OP_DATA) || (q_head.op == cfrc_pkg::OP_CRC_HI);
  assign q_pop     = q_not_empty && (!needs_out || !out_valid || out_ready);
  assign emit      = q_pop && needs_out;

  assign crc_seed = (q_head.op == cfrc_pkg::OP_START) ? cfrc_pkg::CRC_INIT : running_crc;
  assign crc_next = cfrc_pkg::crc_update(crc_seed, q_head.rx);
  assign good     = (got_crc_low == running_crc[7:0]) && (q_head.rx == running_crc[15:8]);

  // Update CRC state per request
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= cfrc_pkg::CRC_INIT;
      got_crc_low <= 8'd0;
    end else if (q_pop) begin
      case (q_head.op)
        cfrc_pkg::OP_START: begin
          running_crc <= crc_next;
          got_crc_low <= 8'd0;
        end
        cfrc_pkg::OP_HDR, cfrc_pkg::OP_DATA: begin
          running_crc <= crc_next;
        end
        cfrc_pkg::OP_CRC_LO: begin
          got_crc_low <= q_head.rx;
        end
        cfrc_pkg::OP_CRC_HI: begin
          running_crc <= cfrc_pkg::CRC_INIT;
        end
        default: begin
          running_crc <= running_crc;
        end
      endcase
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_is_read <= q_head.is_read;
      out_func    <= q_head.func;
      out_len     <= q_head.len;
      if (q_head.op == cfrc_pkg::OP_DATA) begin
        out_kind <= cfrc_pkg::KIND_PAYLOAD;
        out_data <= q_head.rx;
        out_last <= 1'b0;
      end else begin
        out_kind <= good ? cfrc_pkg::KIND_GOOD : cfrc_pkg::KIND_BAD_CRC;
        out_data <= 8'd0;
        out_last <= 1'b1;
      end
    end
  end

endmodule
